FILE: rtl/core/mcal_pkg.sv
`default_nettype none
package mcal_pkg;

    // Block dimensions.
    localparam int CHANNELS   = 10;
    localparam int CURVES     = 4;
    localparam int CURVE_LAST = 200;
    localparam int GRID_SIDE  = 5;

    localparam int PINS       = GRID_SIDE * GRID_SIDE;
    localparam int CH_IDX_W   = $clog2(CHANNELS);
    localparam int CURVE_SPAN = 256;
    localparam int CURVE_W    = $clog2(CURVES);
    localparam int RAM_DEPTH  = CURVES * CURVE_SPAN;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);
    localparam int SUM_W      = 24;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    // Action codes.
    localparam logic [2:0] ACT_SAMPLE    = 3'd0;
    localparam logic [2:0] ACT_CONFIGURE = 3'd1;
    localparam logic [2:0] ACT_ENABLE    = 3'd2;
    localparam logic [2:0] ACT_DISABLE   = 3'd3;
    localparam logic [2:0] ACT_REPORT    = 3'd4;
    localparam logic [2:0] ACT_LOAD      = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_LOOK,
        S_LWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]         action;
        logic [3:0]         channel;
        logic [2:0]         in_col;
        logic [2:0]         in_row;
        logic [2:0]         drive_col;
        logic [2:0]         drive_row;
        logic [1:0]         curve_select;
        logic [7:0]         window_len;
        logic signed [15:0] sample_value;
        logic [7:0]         curve_index;
        logic [15:0]        curve_word;
    } t_in;

    typedef struct packed {
        logic               status;
        logic               drive_valid;
        logic [4:0]         drive_pin;
        logic [15:0]        drive_value;
        logic signed [15:0] report_input;
        logic [15:0]        report_output;
        logic [PINS-1:0]    active_pins;
    } t_out;

    typedef struct packed {
        logic latch;
        logic exec;
        logic div_step;
        logic look;
        logic lwait;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_stat;

    // Saturate a one based grid coordinate into 1..GRID_SIDE.
    function automatic logic [2:0] sat_coord(input logic [2:0] c);
        logic [2:0] r;
        if (c == 3'd0) begin
            r = 3'd1;
        end else if (c > 3'(GRID_SIDE)) begin
            r = 3'(GRID_SIDE);
        end else begin
            r = c;
        end
        return r;
    endfunction

    // Pin number from saturated one based row and column.
    function automatic logic [4:0] pin_of(input logic [2:0] row, input logic [2:0] col);
        logic [4:0] rr;
        logic [4:0] cc;
        rr = {2'b00, row - 3'd1};
        cc = {2'b00, col - 3'd1};
        return 5'(rr * 5'(GRID_SIDE)) + cc;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mcal_ram.sv
`default_nettype none
module mcal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/mcal_ctrl.sv
`default_nettype none
module mcal_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire mcal_pkg::t_stat i_stat,
    output mcal_pkg::t_cmd       o_cmd,
    output logic                 o_in_ready,
    output mcal_pkg::t_state     o_state
);
    import mcal_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_div ? S_DIV : S_OUT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_LWAIT;
            end
            S_LWAIT: begin
                o_cmd.lwait = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_state    = r_state;

endmodule
`default_nettype wire

FILE: rtl/core/mcal_dp.sv
`default_nettype none
module mcal_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mcal_pkg::t_in  i_in_data,
    input  wire mcal_pkg::t_cmd i_cmd,
    input  wire logic           i_out_ready,
    output mcal_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    output mcal_pkg::t_out      o_out_data
);
    import mcal_pkg::*;

    // Held item and pending result.
    t_in  r_item;
    t_out r_res;
    t_out n_res;

    // Per channel state.
    logic                    r_en      [CHANNELS];
    logic [4:0]              r_in_pin  [CHANNELS];
    logic [4:0]              r_out_pin [CHANNELS];
    logic                    r_has_out [CHANNELS];
    logic [CURVE_W-1:0]      r_curve   [CHANNELS];
    logic [7:0]              r_win     [CHANNELS];
    logic [7:0]              r_tick    [CHANNELS];
    logic signed [SUM_W-1:0] r_sum     [CHANNELS];
    logic signed [15:0]      r_in_val  [CHANNELS];
    logic [15:0]             r_out_val [CHANNELS];
    logic [PINS-1:0]         r_mask;

    logic                    n_en      [CHANNELS];
    logic [4:0]              n_in_pin  [CHANNELS];
    logic [4:0]              n_out_pin [CHANNELS];
    logic                    n_has_out [CHANNELS];
    logic [CURVE_W-1:0]      n_curve   [CHANNELS];
    logic [7:0]              n_win     [CHANNELS];
    logic [7:0]              n_tick    [CHANNELS];
    logic signed [SUM_W-1:0] n_sum     [CHANNELS];
    logic signed [15:0]      n_in_val  [CHANNELS];
    logic [15:0]             n_out_val [CHANNELS];
    logic [PINS-1:0]         n_mask;

    // Divider state.
    logic [8:0]              r_rem;
    logic [SUM_W-1:0]        r_quo;
    logic                    r_neg;
    logic [DCNT_W-1:0]       r_dcnt;

    logic [CH_IDX_W-1:0]     ch;
    logic                    ch_ok;
    logic [CURVE_W-1:0]      sel;
    logic [7:0]              tick_inc;
    logic signed [SUM_W-1:0] s_ext;
    logic signed [SUM_W-1:0] dividend;
    logic                    need_div;
    logic [4:0]              pin_new;
    logic                    ram_we;
    logic [RAM_AW-1:0]       ram_waddr;
    logic [RAM_AW-1:0]       ram_raddr;
    logic [15:0]             ram_rdata;
    logic [8:0]              rem_sh;
    logic                    rem_ge;
    logic [SUM_W-1:0]        avg;
    logic [7:0]              idx;

    logic                    r_ovalid;
    t_out                    r_odata;

    assign ch       = r_item.channel[CH_IDX_W-1:0];
    assign ch_ok    = (r_item.channel < 4'(CHANNELS));
    assign sel      = r_item.curve_select[CURVE_W-1:0];
    assign tick_inc = r_tick[ch] + 8'd1;
    assign s_ext    = SUM_W'(r_item.sample_value);
    assign dividend = r_sum[ch] + s_ext;
    assign pin_new  = pin_of(sat_coord(r_item.in_row), sat_coord(r_item.in_col));

    // Action decode and channel state update.
    always_comb begin
        n_en      = r_en;
        n_in_pin  = r_in_pin;
        n_out_pin = r_out_pin;
        n_has_out = r_has_out;
        n_curve   = r_curve;
        n_win     = r_win;
        n_tick    = r_tick;
        n_sum     = r_sum;
        n_in_val  = r_in_val;
        n_out_val = r_out_val;
        n_mask    = r_mask;
        n_res     = '0;
        need_div  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {sel, r_item.curve_index};
        if (r_item.action == ACT_LOAD) begin
            if (r_item.curve_index > 8'(CURVE_LAST)) begin
                n_res.status = 1'b1;
            end else begin
                ram_we = 1'b1;
            end
        end else if (r_item.action > ACT_LOAD || !ch_ok) begin
            n_res.status = 1'b1;
        end else begin
            case (r_item.action)
                ACT_SAMPLE: begin
                    if (r_en[ch]) begin
                        n_in_val[ch] = r_item.sample_value;
                        if (tick_inc >= r_win[ch]) begin
                            need_div   = 1'b1;
                            n_tick[ch] = 8'd0;
                            n_sum[ch]  = '0;
                            if (r_has_out[ch]) begin
                                n_res.drive_valid = 1'b1;
                                n_res.drive_pin   = r_out_pin[ch];
                            end
                        end else begin
                            n_tick[ch] = tick_inc;
                            n_sum[ch]  = dividend;
                        end
                    end
                end
                ACT_CONFIGURE: begin
                    n_in_pin[ch] = pin_new;
                    if (r_item.drive_col == 3'd0 || r_item.drive_row == 3'd0) begin
                        n_has_out[ch] = 1'b0;
                        n_out_pin[ch] = 5'd0;
                    end else begin
                        n_has_out[ch] = 1'b1;
                        n_out_pin[ch] = pin_of(sat_coord(r_item.drive_row),
                                               sat_coord(r_item.drive_col));
                    end
                    n_curve[ch]   = sel;
                    n_win[ch]     = (r_item.window_len == 8'd0) ? 8'd1 : r_item.window_len;
                    n_tick[ch]    = 8'd0;
                    n_sum[ch]     = '0;
                    n_mask        = r_mask | (PINS'(1) << pin_new);
                    n_in_val[ch]  = '0;
                    n_out_val[ch] = 16'd0;
                    n_en[ch]      = 1'b1;
                end
                ACT_ENABLE, ACT_DISABLE: begin
                    if (r_en[ch] == (r_item.action == ACT_ENABLE)) begin
                        n_res.status = 1'b1;
                    end else begin
                        if (r_item.action == ACT_ENABLE) begin
                            n_mask        = r_mask | (PINS'(1) << r_in_pin[ch]);
                            n_in_val[ch]  = '0;
                            n_out_val[ch] = 16'd0;
                        end else begin
                            n_mask = r_mask & ~(PINS'(1) << r_in_pin[ch]);
                        end
                        n_en[ch] = (r_item.action == ACT_ENABLE);
                        if (r_has_out[ch]) begin
                            n_res.drive_valid = 1'b1;
                            n_res.drive_pin   = r_out_pin[ch];
                        end
                    end
                end
                ACT_REPORT: begin
                    if (r_en[ch]) begin
                        n_res.report_input  = r_in_val[ch];
                        n_res.report_output = r_out_val[ch];
                    end else begin
                        n_res.status = 1'b1;
                    end
                end
                default: begin
                    n_res.status = 1'b1;
                end
            endcase
        end
        n_res.active_pins = n_mask;
    end

    // One restoring division step on the magnitude.
    assign rem_sh = {r_rem[7:0], r_quo[SUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_win[ch]});

    // Signed average and clamped curve index.
    assign avg       = r_neg ? (SUM_W'(0) - r_quo) : r_quo;
    assign idx       = r_neg ? 8'd0 :
                       (r_quo > SUM_W'(CURVE_LAST)) ? 8'(CURVE_LAST) : r_quo[7:0];
    assign ram_raddr = {r_curve[ch], idx};

    // Channel registers and the pin mask.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_en[i]      <= 1'b0;
                r_in_pin[i]  <= 5'd0;
                r_out_pin[i] <= 5'd0;
                r_has_out[i] <= 1'b0;
                r_curve[i]   <= '0;
                r_win[i]     <= 8'd1;
                r_tick[i]    <= 8'd0;
                r_sum[i]     <= '0;
                r_in_val[i]  <= '0;
                r_out_val[i] <= 16'd0;
            end
            r_mask <= '0;
        end else if (i_cmd.exec) begin
            r_en      <= n_en;
            r_in_pin  <= n_in_pin;
            r_out_pin <= n_out_pin;
            r_has_out <= n_has_out;
            r_curve   <= n_curve;
            r_win     <= n_win;
            r_tick    <= n_tick;
            r_sum     <= n_sum;
            r_in_val  <= n_in_val;
            r_out_val <= n_out_val;
            r_mask    <= n_mask;
        end else if (i_cmd.look) begin
            r_in_val[ch] <= avg[15:0];
        end else if (i_cmd.lwait) begin
            r_out_val[ch] <= ram_rdata;
        end
    end

    // Payload registers and the divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_res  <= n_res;
            r_neg  <= dividend[SUM_W-1];
            r_quo  <= dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
            r_rem  <= 9'd0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? (rem_sh - {1'b0, r_win[ch]}) : rem_sh;
            r_quo  <= {r_quo[SUM_W-2:0], rem_ge};
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end else if (i_cmd.lwait && r_has_out[ch]) begin
            r_res.drive_value <= ram_rdata;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= r_res;
        end
    end

    mcal_ram #(
        .WIDTH (16),
        .DEPTH (RAM_DEPTH)
    ) u_curve_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we && i_cmd.exec),
        .i_waddr (ram_waddr),
        .i_wdata (r_item.curve_word),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.need_div = need_div;
    assign o_stat.div_last = (r_dcnt == DCNT_W'(DIV_STEPS - 1));
    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid     = r_ovalid;
    assign o_out_data      = r_odata;

endmodule
`default_nettype wire

FILE: rtl/core/multichannel_average_linearizer.sv
// Ten channel boxcar averaging linearizer.
// Input channel: i_in_valid / o_in_ready carry one action beat (sample,
// configure, enable, disable, report, load curve word) in i_in_data.
// Output channel: o_out_valid / i_out_ready carry exactly one result beat
// per action in o_out_data: status, pin drive, report values and pin mask.
// An action that needs no average is decoded and then loaded into the output
// register. A sample that closes its window first runs a restoring divider,
// one quotient bit per cycle, then one curve RAM read and a wait for its data.
// One action is in flight at a time: a new beat is accepted only once the
// previous action has been loaded into the output register.
// The output register lets a new action be accepted while the previous
// result waits; a stalled receiver holds the next result in its final
// state, and no further action is accepted until it is stored.
// Reset clears all channel state and the pin mask; curve words are not
// cleared and must be loaded before they are looked up.
`default_nettype none
module multichannel_average_linearizer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mcal_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output mcal_pkg::t_out      o_out_data
);
    import mcal_pkg::*;

    t_cmd   cmd;
    t_stat  stat;
    t_state state;

    mcal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready),
        .o_state    (state)
    );

    mcal_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // An accepted beat is always decoded in the next cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (state == S_EXEC))
        else $error("accepted beat not decoded");

    // The curve read data is consumed right after the read address cycle.
    a_look_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == S_LOOK) |=> (state == S_LWAIT))
        else $error("curve read not followed by wait");

    // A refused action never drives an output pin.
    a_refused_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status) |-> !o_out_data.drive_valid)
        else $error("refused action drives a pin");

    // A result is only loaded while no item is being accepted.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !o_in_ready)
        else $error("result load while accepting");

endmodule
`default_nettype wire

FILE: dv/tb_multichannel_average_linearizer.sv
`default_nettype none
module tb_multichannel_average_linearizer;
    import mcal_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    multichannel_average_linearizer uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    localparam int WATCHDOG_LIMIT = 20000;

    // Predictor state for the ten channels and the curve words.
    logic                en_q   [CHANNELS];
    logic [4:0]          inpin_q[CHANNELS];
    logic [4:0]          outpin_q[CHANNELS];
    logic                hasout_q[CHANNELS];
    logic [1:0]          curve_q[CHANNELS];
    logic [7:0]          win_q  [CHANNELS];
    logic [7:0]          tick_q [CHANNELS];
    int                  sum_q  [CHANNELS];
    int                  inval_q[CHANNELS];
    logic [15:0]         outval_q[CHANNELS];
    logic [PINS-1:0]     mask_q;
    logic [15:0]         curve_mem[CURVES*256];

    t_in  pending_beats[$];
    t_out expected_results[$];
    int   fail_count;
    int   idle_cycles;
    int   in_gap;
    int   out_gap;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [2:0] clamp_coord(input logic [2:0] c);
        if (c == 3'd0) return 3'd1;
        if (c > 3'd5) return 3'd5;
        return c;
    endfunction

    // Compute the result of one action and update the predictor state.
    function automatic t_out linearize_action(input t_in b);
        t_out r;
        int ch;
        int s;
        int avg;
        int idx;
        logic [2:0] ic;
        logic [2:0] ir;
        r = '0;
        ch = b.channel;
        if (b.action == ACT_LOAD) begin
            if (b.curve_index > 8'd200) begin
                r.status = 1'b1;
            end else begin
                curve_mem[b.curve_select*256 + b.curve_index] = b.curve_word;
            end
        end else if (b.action > ACT_LOAD || ch >= CHANNELS) begin
            r.status = 1'b1;
        end else if (b.action == ACT_SAMPLE) begin
            if (en_q[ch]) begin
                s = b.sample_value;
                inval_q[ch] = s;
                tick_q[ch] = tick_q[ch] + 8'd1;
                if (tick_q[ch] >= win_q[ch]) begin
                    tick_q[ch] = '0;
                    avg = (sum_q[ch] + s) / int'(win_q[ch]);
                    inval_q[ch] = avg;
                    idx = avg < 0 ? 0 : (avg > CURVE_LAST ? CURVE_LAST : avg);
                    outval_q[ch] = curve_mem[curve_q[ch]*256 + idx];
                    if (hasout_q[ch]) begin
                        r.drive_valid = 1'b1;
                        r.drive_pin = outpin_q[ch];
                        r.drive_value = outval_q[ch];
                    end
                    sum_q[ch] = 0;
                end else begin
                    sum_q[ch] += s;
                end
            end
        end else if (b.action == ACT_CONFIGURE) begin
            ic = clamp_coord(b.in_col);
            ir = clamp_coord(b.in_row);
            inpin_q[ch] = 5'((ir - 1) * 5 + (ic - 1));
            if (b.drive_col == 0 || b.drive_row == 0) begin
                hasout_q[ch] = 1'b0;
                outpin_q[ch] = '0;
            end else begin
                hasout_q[ch] = 1'b1;
                outpin_q[ch] = 5'((clamp_coord(b.drive_row) - 1) * 5
                                  + (clamp_coord(b.drive_col) - 1));
            end
            curve_q[ch] = b.curve_select;
            win_q[ch] = (b.window_len == 0) ? 8'd1 : b.window_len;
            tick_q[ch] = '0;
            sum_q[ch] = 0;
            mask_q[inpin_q[ch]] = 1'b1;
            inval_q[ch] = 0;
            outval_q[ch] = '0;
            en_q[ch] = 1'b1;
        end else if (b.action == ACT_ENABLE || b.action == ACT_DISABLE) begin
            if (en_q[ch] == (b.action == ACT_ENABLE)) begin
                r.status = 1'b1;
            end else begin
                if (b.action == ACT_ENABLE) begin
                    mask_q[inpin_q[ch]] = 1'b1;
                    inval_q[ch] = 0;
                    outval_q[ch] = '0;
                end else begin
                    mask_q[inpin_q[ch]] = 1'b0;
                end
                en_q[ch] = (b.action == ACT_ENABLE);
                if (hasout_q[ch]) begin
                    r.drive_valid = 1'b1;
                    r.drive_pin = outpin_q[ch];
                end
            end
        end else begin
            if (en_q[ch]) begin
                r.report_input = 16'(inval_q[ch]);
                r.report_output = outval_q[ch];
            end else begin
                r.status = 1'b1;
            end
        end
        r.active_pins = mask_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h expected 0x%0h", what, got, want);
        fail_count++;
    endtask

    // Driver: presents queued beats with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // Hold the beat until it is taken.
        end else if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            i_in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
            i_in_data <= pending_beats.pop_front();
            i_in_valid <= 1'b1;
            in_gap <= gap_len();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Predict on acceptance; check results; apply receiver stalls.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap <= 0;
            idle_cycles <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(linearize_action(i_in_data));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", o_out_data.status, want.status);
                    if (o_out_data.drive_valid !== want.drive_valid)
                        report_mismatch("drive_valid", o_out_data.drive_valid,
                                        want.drive_valid);
                    if (o_out_data.drive_pin !== want.drive_pin)
                        report_mismatch("drive_pin", o_out_data.drive_pin, want.drive_pin);
                    if (o_out_data.drive_value !== want.drive_value)
                        report_mismatch("drive_value", o_out_data.drive_value,
                                        want.drive_value);
                    if (o_out_data.report_input !== want.report_input)
                        report_mismatch("report_input", o_out_data.report_input,
                                        want.report_input);
                    if (o_out_data.report_output !== want.report_output)
                        report_mismatch("report_output", o_out_data.report_output,
                                        want.report_output);
                    if (o_out_data.active_pins !== want.active_pins)
                        report_mismatch("active_pins", o_out_data.active_pins,
                                        want.active_pins);
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid && i_out_ready) out_gap <= gap_len();
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Queue one beat for the driver.
    task automatic queue_beat(input t_in b);
        pending_beats.push_back(b);
    endtask

    function automatic t_in random_fields();
        t_in b;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        b = raw[$bits(t_in)-1:0];
        return b;
    endfunction

    function automatic logic signed [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($urandom_range(0, 200));
        if (r < 8) return 16'($signed($urandom_range(0, 400)) - 100);
        return 16'($urandom);
    endfunction

    initial begin
        t_in b;
        int r;
        i_rst_n = 1'b0;
        fail_count = 0;
        for (int c = 0; c < CHANNELS; c++) begin
            en_q[c] = 0; inpin_q[c] = 0; outpin_q[c] = 0; hasout_q[c] = 0;
            curve_q[c] = 0; win_q[c] = 1; tick_q[c] = 0; sum_q[c] = 0;
            inval_q[c] = 0; outval_q[c] = 0;
        end
        mask_q = '0;
        // Every curve point is loaded first, so no sample reads an unwritten one.
        for (int k = 0; k < CURVES*256; k++) begin
            curve_mem[k] = '0;
        end
        for (int cv = 0; cv < CURVES; cv++) begin
            for (int p = 0; p <= CURVE_LAST; p++) begin
                b = random_fields();
                b.action = ACT_LOAD;
                b.curve_select = 2'(cv);
                b.curve_index = 8'(p);
                if (p == 0) b.curve_word = 16'hFFFF;
                else if (p == 1) b.curve_word = 16'h0000;
                queue_beat(b);
            end
        end
        // Directed beats: refusals, pin saturation, window extremes.
        b = random_fields(); b.action = ACT_LOAD; b.curve_index = 8'd201; queue_beat(b);
        b = random_fields(); b.action = ACT_LOAD; b.curve_index = 8'd255; queue_beat(b);
        b = random_fields(); b.action = 3'd6; queue_beat(b);
        b = random_fields(); b.action = 3'd7; queue_beat(b);
        b = random_fields(); b.action = ACT_REPORT; b.channel = 4'd15; queue_beat(b);
        b = random_fields(); b.action = ACT_CONFIGURE; b.channel = 4'd10; queue_beat(b);
        b = random_fields(); b.action = ACT_REPORT; b.channel = 4'd0; queue_beat(b);
        b = random_fields(); b.action = ACT_DISABLE; b.channel = 4'd0; queue_beat(b);
        b = random_fields(); b.action = ACT_SAMPLE; b.channel = 4'd0; queue_beat(b);
        b = random_fields(); b.action = ACT_CONFIGURE; b.channel = 4'd0;
        b.in_col = 0; b.in_row = 7; b.drive_col = 7; b.drive_row = 7;
        b.window_len = 0; queue_beat(b);
        b = random_fields(); b.action = ACT_SAMPLE; b.channel = 4'd0;
        b.sample_value = 16'sh8000; queue_beat(b);
        b = random_fields(); b.action = ACT_SAMPLE; b.channel = 4'd0;
        b.sample_value = 16'sh7FFF; queue_beat(b);
        b = random_fields(); b.action = ACT_ENABLE; b.channel = 4'd0; queue_beat(b);
        b = random_fields(); b.action = ACT_REPORT; b.channel = 4'd0; queue_beat(b);
        b = random_fields(); b.action = ACT_CONFIGURE; b.channel = 4'd9;
        b.in_col = 5; b.in_row = 5; b.drive_col = 0; b.drive_row = 3;
        b.window_len = 8'd255; queue_beat(b);
        for (int k = 0; k < 3; k++) begin
            b = random_fields(); b.action = ACT_SAMPLE; b.channel = 4'd9;
            b.sample_value = 16'sh7FFF; queue_beat(b);
        end
        b = random_fields(); b.action = ACT_DISABLE; b.channel = 4'd0; queue_beat(b);
        b = random_fields(); b.action = ACT_ENABLE; b.channel = 4'd0; queue_beat(b);
        b = random_fields(); b.action = ACT_REPORT; b.channel = 4'd9; queue_beat(b);
        // Random part: mostly samples on channels 0 to 9; configures pick small windows.
        for (int n = 0; n < 1175; n++) begin
            b = random_fields();
            r = $urandom_range(0, 99);
            if (r < 55) begin
                b.action = ACT_SAMPLE;
                b.channel = 4'($urandom_range(0, 9));
                b.sample_value = pick_sample();
            end else if (r < 65) begin
                b.action = ACT_CONFIGURE;
                b.channel = 4'($urandom_range(0, 9));
                b.window_len = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 4));
            end else if (r < 73) begin
                b.action = ACT_ENABLE;
                b.channel = 4'($urandom_range(0, 9));
            end else if (r < 81) begin
                b.action = ACT_DISABLE;
                b.channel = 4'($urandom_range(0, 9));
            end else if (r < 91) begin
                b.action = ACT_REPORT;
                b.channel = 4'($urandom_range(0, 9));
            end else if (r < 97) begin
                b.action = ACT_LOAD;
            end
            queue_beat(b);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_beats.size() > 0 || i_in_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin
        @(posedge i_rst_n);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
